### rtl/sorted_priority_queue_top_assert.svh
// assertion macros for the sorted priority queue checker
// included by the checker file only, no other dependencies
`ifndef SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define SPQ_ASSERT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define SPQ_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/spq_pkg.sv
// shared types and constants for the sorted priority queue
// no dependencies
package spq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int OP_W    = 2;
  localparam int ID_W    = 16;
  localparam int PRIO_W  = 8;
  localparam int STAT_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 2'd0,
    OP_POP_HIGH = 2'd1,
    OP_POP_LOW  = 2'd2,
    OP_REMOVE   = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

### rtl/spq_if.sv
// valid/ready channel interfaces for the queue's request and result items
// depends on spq_pkg
interface spq_in_if;
  import spq_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [ID_W-1:0]   entry_id;
  logic [PRIO_W-1:0] entry_priority;

  modport source (output valid, output opcode, output entry_id, output entry_priority,
                  input ready);
  modport sink (input valid, input opcode, input entry_id, input entry_priority,
                output ready);
endinterface

interface spq_out_if;
  import spq_pkg::*;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ID_W-1:0]   out_id;
  logic [PRIO_W-1:0] out_priority;

  modport source (output valid, output status, output out_id, output out_priority,
                  input ready);
  modport sink (input valid, input status, input out_id, input out_priority,
                output ready);
endinterface

### rtl/spq_ram.sv
// generic single-write, single-read RAM with registered read data
// no dependencies
module spq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

### rtl/sorted_priority_queue_top.sv
// Sorted priority queue: in_ch takes one request item (opcode, entry_id,
// entry_priority), out_ch returns exactly one result item (status, out_id,
// out_priority) for each request. Valid/ready on both channels.
// Entries are held in a RAM, ordered from highest to lowest priority; equal
// priorities keep insertion order.
// Every operation but an insert into a full queue is one forward walk over
// the RAM by a small sequencer: one read issued per cycle, each read entry
// compared in the cycle after its read, and a write back to the same or the
// previous slot. An insert into a full queue skips the walk.
// in_ch.ready is high only while the sequencer is idle, so one item is in
// work at a time.
// The result sits in an output register; if out_ch is stalled the next item
// may still be accepted and walked, and only its result write-back waits.
// Reset (rst, synchronous) empties the queue and drops any pending result;
// RAM contents are not cleared, only slots below the fill count are read.
// Depends on spq_pkg, spq_if, spq_ram.
module sorted_priority_queue_top #(
  parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
  input logic clk,
  input logic rst,
  spq_in_if.sink    in_ch,
  spq_out_if.source out_ch
);
  import spq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  state_t              state, state_next;
  logic [CW-1:0]       occ;
  logic [CW-1:0]       ridx;
  logic [AW-1:0]       pidx;
  logic                dv;
  logic                found;
  op_t                 op;
  logic [ID_W-1:0]     key_id;
  logic [PRIO_W-1:0]   key_prio;
  entry_t              hold;
  entry_t              got;

  logic                out_valid;
  logic [STAT_W-1:0]   out_status;
  logic [ID_W-1:0]     out_id_r;
  logic [PRIO_W-1:0]   out_prio_r;

  logic                accept;
  logic                fin_fire;
  logic                is_full;
  logic                match;
  entry_t              rd_entry;
  logic [ENTRY_W-1:0]  rd_data;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  entry_t              wr_entry;
  status_t             fin_status;

  assign accept   = in_ch.valid && in_ch.ready;
  assign fin_fire = (state == S_FIN) && (!out_valid || out_ch.ready);
  assign is_full  = (occ == FULL_CNT);
  assign rd_entry = entry_t'(rd_data);

  // compare rule of the current walk
  always_comb begin
    unique case (op)
      OP_INSERT:   match = (rd_entry.prio < key_prio);
      OP_POP_HIGH: match = 1'b1;
      OP_POP_LOW:  match = 1'b1;
      OP_REMOVE:   match = (rd_entry.id == key_id);
      default:     match = 1'b0;
    endcase
  end

  always_comb begin
    unique case (op)
      OP_INSERT:   fin_status = is_full ? ST_FULL : ST_OK;
      OP_POP_HIGH: fin_status = found ? ST_OK : ST_EMPTY;
      OP_POP_LOW:  fin_status = found ? ST_OK : ST_EMPTY;
      OP_REMOVE:   fin_status = found ? ST_OK : ST_NOT_FOUND;
      default:     fin_status = ST_OK;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if ((op_t'(in_ch.opcode) == OP_INSERT) && is_full) begin
            state_next = S_FIN;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (!dv && (ridx >= occ)) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_fire) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs: handshake and RAM ports
  always_comb begin
    in_ch.ready = (state == S_IDLE);
    rd_en       = (state == S_SCAN) && (ridx < occ);
    rd_addr     = ridx[AW-1:0];
    wr_en       = 1'b0;
    wr_addr     = pidx;
    wr_entry    = hold;
    if (dv) begin
      if (op == OP_INSERT) begin
        // ripple the displaced entry one slot toward the tail
        wr_en    = found || match;
        wr_addr  = pidx;
        wr_entry = hold;
      end else begin
        // close the gap behind the removed entry
        wr_en    = found;
        wr_addr  = pidx - AW'(1);
        wr_entry = rd_entry;
      end
    end else if (fin_fire && (op == OP_INSERT) && !is_full) begin
      wr_en    = 1'b1;
      wr_addr  = occ[AW-1:0];
      wr_entry = hold;
    end
  end

  spq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (ENTRY_W'(wr_entry)),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      dv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      dv    <= rd_en;
      if (fin_fire) begin
        out_valid <= 1'b1;
        if (op == OP_INSERT) begin
          if (!is_full) begin
            occ <= occ + CW'(1);
          end
        end else if (found) begin
          occ <= occ - CW'(1);
        end
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // walk datapath, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      op        <= op_t'(in_ch.opcode);
      key_id    <= in_ch.entry_id;
      key_prio  <= in_ch.entry_priority;
      hold.id   <= in_ch.entry_id;
      hold.prio <= in_ch.entry_priority;
      got       <= '0;
      found     <= 1'b0;
      if ((op_t'(in_ch.opcode) == OP_POP_LOW) && (occ != '0)) begin
        ridx <= occ - CW'(1);
      end else begin
        ridx <= '0;
      end
    end
    if (rd_en) begin
      ridx <= ridx + CW'(1);
      pidx <= ridx[AW-1:0];
    end
    if (dv) begin
      if (op == OP_INSERT) begin
        if (found || match) begin
          found <= 1'b1;
          hold  <= rd_entry;
        end
      end else if (!found && match) begin
        found <= 1'b1;
        got   <= rd_entry;
      end
    end
    if (fin_fire) begin
      out_status <= STAT_W'(fin_status);
      out_id_r   <= got.id;
      out_prio_r <= got.prio;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.status       = out_status;
  assign out_ch.out_id       = out_id_r;
  assign out_ch.out_priority = out_prio_r;

endmodule

### rtl/spq_checker.sv
// port-level checks for the sorted priority queue, bound to the top level
// depends on spq_pkg and sorted_priority_queue_top_assert.svh
`include "sorted_priority_queue_top_assert.svh"

module spq_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [spq_pkg::STAT_W-1:0] out_status,
  input logic [spq_pkg::ID_W-1:0]   out_id,
  input logic [spq_pkg::PRIO_W-1:0] out_priority
);
  import spq_pkg::*;

  // result held while the receiver stalls
  `SPQ_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result item dropped while stalled")
  `SPQ_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(out_status) && $stable(out_id) && $stable(out_priority), "stalled result item changed")
  // one request in work at a time
  `SPQ_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready, "request taken while busy")
  // failed operations remove nothing
  `SPQ_ASSERT(a_fail_zero, clk, rst, out_valid && (out_status != STAT_W'(ST_OK)), (out_id == '0) && (out_priority == '0), "nonzero entry on failed operation")
  // reset drops any pending result
  `SPQ_ASSERT_NEXT_ALWAYS(a_reset_clear, clk, rst, !out_valid, "result valid right after reset")

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_status   (out_ch.status),
  .out_id       (out_ch.out_id),
  .out_priority (out_ch.out_priority)
);
